>>> rtl/llas_pkg.sv
// ----------------------------------------------------------------------------
// llas_pkg: shared types and constants of the life-like automaton step unit
// Field widths, register indexes, rule thresholds and per-cell position info.
// ----------------------------------------------------------------------------
`default_nettype none

package llas_pkg;

    localparam int unsigned DEFAULT_MAX_COLUMNS = 1024;
    localparam int unsigned DEFAULT_MAX_ROWS    = 1024;
    localparam int unsigned GRID_RESET          = 1024;

    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned OUT_IDX_W  = 10;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned COLUMN_W   = 3;
    localparam int unsigned WINDOW_CELLS = 2;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [COUNT_W-1:0] RULE_COUNT_LO = 4'd2;
    localparam logic [COUNT_W-1:0] RULE_COUNT_HI = 4'd3;

    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } cell_pos_t;

endpackage

`default_nettype wire

>>> rtl/llas_col_cell.sv
// ----------------------------------------------------------------------------
// llas_col_cell: one column cell of the 3x3 window chain
// Holds a three-cell column and hands it to the next cell on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module llas_col_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift,
    input  wire logic [llas_pkg::COLUMN_W-1:0]  col_in,
    output logic      [llas_pkg::COLUMN_W-1:0]  col_out
);

    logic [llas_pkg::COLUMN_W-1:0] col_reg;
    logic [llas_pkg::COLUMN_W-1:0] col_next;

    always_comb
    begin
        col_next = shift ? col_in : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

>>> rtl/llas_line_buffer.sv
// ----------------------------------------------------------------------------
// llas_line_buffer: two-row line store
// One entry per padded column: bit 1 row r-2, bit 0 row r-1. Registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module llas_line_buffer #(
    parameter int unsigned DEPTH = llas_pkg::DEFAULT_MAX_COLUMNS + 2,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [1:0]        rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [1:0]        wr_data
);

    logic [1:0] store_mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/life_like_automaton_step_unit.sv
// ----------------------------------------------------------------------------
// life_like_automaton_step_unit: one B23/S23 generation over a padded raster
// Pipe: two stages from the input transfer to m_tvalid. Throughput: one padded
// cell per cycle unless m_tready stalls, set by the single-port-per-side line store.
// Reset: counters cleared, grid size 1024 x 1024 (clamped to the maximums).
// Reset does not clear the line store; every entry is rewritten in the first
// two padded rows of a frame before it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_step_unit #(
    parameter int unsigned MAX_COLUMNS = llas_pkg::DEFAULT_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = llas_pkg::DEFAULT_MAX_ROWS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // cfg_data: grid_width or grid_height by cfg_index
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [llas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [llas_pkg::CFG_DATA_W-1:0]   cfg_data,
    // s_tdata: [0] cell_alive, [7:1] zero
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [llas_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: [0] next_alive, [10:1] out_row, [20:11] out_col, [23:21] zero
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [llas_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                   m_tlast
);

    localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 2);
    localparam int unsigned ROW_W = $clog2(MAX_ROWS + 2);
    localparam int unsigned W_RST =
        (llas_pkg::GRID_RESET > MAX_COLUMNS) ? MAX_COLUMNS : llas_pkg::GRID_RESET;
    localparam int unsigned H_RST =
        (llas_pkg::GRID_RESET > MAX_ROWS) ? MAX_ROWS : llas_pkg::GRID_RESET;
    localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(W_RST + 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(H_RST + 1);

    function automatic logic [31:0] clamp_last(
        input logic [llas_pkg::CFG_DATA_W-1:0] v,
        input int unsigned                     mx
    );
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
        begin
            return 32'd2;
        end
        if (v32 > mx)
        begin
            return mx + 32'd1;
        end
        return v32 + 32'd1;
    endfunction

    logic [COL_W-1:0] col_last_reg, col_last_next;
    logic [ROW_W-1:0] row_last_reg, row_last_next;
    logic [COL_W-1:0] c_reg, c_next;
    logic [ROW_W-1:0] r_reg, r_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_v_reg;
    logic [COL_W-1:0]       s1_addr_reg;
    llas_pkg::cell_pos_t    s1_pos_reg;

    logic                                   m_valid_reg, m_valid_next;
    logic                                   m_alive_reg;
    llas_pkg::cell_pos_t                    m_pos_reg;

    logic        en;
    logic        accept;
    logic        cfg_hit;
    logic        cfg_wr;
    logic        interior;
    logic        v_in;
    logic [31:0] col_ext, row_ext, w_last32, h_last32;
    logic [31:0] row_off, col_off;
    llas_pkg::cell_pos_t pos_in;

    logic [1:0] lb_rd_data;
    logic       top, mid;
    logic       shift;
    logic [llas_pkg::COLUMN_W-1:0] col_chain [llas_pkg::WINDOW_CELLS+1];
    logic [llas_pkg::COLUMN_W-1:0] centre_col, outer_col, new_col;
    logic [llas_pkg::COUNT_W-1:0]  count;
    logic                          alive;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;

    always_comb
    begin
        unique case (cfg_index)
            llas_pkg::REG_GRID_WIDTH,
            llas_pkg::REG_GRID_HEIGHT: cfg_hit = 1'b1;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    assign cfg_wr   = cfg_valid && cfg_ready && cfg_hit;
    assign w_last32 = clamp_last(cfg_data, MAX_COLUMNS);
    assign h_last32 = clamp_last(cfg_data, MAX_ROWS);

    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                llas_pkg::REG_GRID_WIDTH:  col_last_next = w_last32[COL_W-1:0];
                llas_pkg::REG_GRID_HEIGHT: row_last_next = h_last32[ROW_W-1:0];
                default:
                begin
                    col_last_next = col_last_reg;
                    row_last_next = row_last_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        c_next = c_reg;
        r_next = r_reg;
        if (cfg_wr)
        begin
            c_next = '0;
            r_next = '0;
        end
        else if (accept)
        begin
            if (c_reg == col_last_reg)
            begin
                c_next = '0;
                r_next = (r_reg == row_last_reg) ? '0 : r_reg + ROW_W'(1);
            end
            else
            begin
                c_next = c_reg + COL_W'(1);
            end
        end
    end

    assign interior = (r_reg != '0) && (r_reg != row_last_reg)
                   && (c_reg != '0) && (c_reg != col_last_reg);
    assign v_in     = s_tdata[0] && interior;
    assign row_ext  = 32'(r_reg);
    assign col_ext  = 32'(c_reg);
    assign row_off  = row_ext - 32'd2;
    assign col_off  = col_ext - 32'd2;

    always_comb
    begin
        pos_in.emit = (r_reg >= ROW_W'(2)) && (c_reg >= COL_W'(2));
        pos_in.last = (r_reg == row_last_reg) && (c_reg == col_last_reg);
        pos_in.row  = row_off[llas_pkg::OUT_IDX_W-1:0];
        pos_in.col  = col_off[llas_pkg::OUT_IDX_W-1:0];
    end

    assign s1_valid_next = en ? accept : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= COL_LAST_RST;
            row_last_reg <= ROW_LAST_RST;
            c_reg        <= '0;
            r_reg        <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            c_reg        <= c_next;
            r_reg        <= r_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_v_reg    <= v_in;
            s1_addr_reg <= c_reg;
            s1_pos_reg  <= pos_in;
        end
    end

    llas_line_buffer #(
        .DEPTH (MAX_COLUMNS + 2)
    ) u_line_buffer (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (c_reg),
        .rd_data (lb_rd_data),
        .wr_en   (shift),
        .wr_addr (s1_addr_reg),
        .wr_data ({lb_rd_data[0], s1_v_reg})
    );

    assign top   = lb_rd_data[1];
    assign mid   = lb_rd_data[0];
    assign shift = en && s1_valid_reg;

    assign new_col      = {s1_v_reg, mid, top};
    assign col_chain[0] = new_col;

    for (genvar i = 0; i < llas_pkg::WINDOW_CELLS; i++)
    begin : g_cell
        llas_col_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .col_in  (col_chain[i]),
            .col_out (col_chain[i+1])
        );
    end

    assign centre_col = col_chain[1];
    assign outer_col  = col_chain[2];

    assign count = llas_pkg::COUNT_W'(new_col[0]) + llas_pkg::COUNT_W'(new_col[1])
                 + llas_pkg::COUNT_W'(new_col[2]) + llas_pkg::COUNT_W'(centre_col[0])
                 + llas_pkg::COUNT_W'(centre_col[2]) + llas_pkg::COUNT_W'(outer_col[0])
                 + llas_pkg::COUNT_W'(outer_col[1]) + llas_pkg::COUNT_W'(outer_col[2]);
    assign alive = (count == llas_pkg::RULE_COUNT_LO) || (count == llas_pkg::RULE_COUNT_HI);

    assign m_valid_next = en ? (s1_valid_reg && s1_pos_reg.emit) : m_valid_reg;

    always_ff @(posedge clk)
    begin
        if (shift && s1_pos_reg.emit)
        begin
            m_alive_reg <= alive;
            m_pos_reg   <= s1_pos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_pos_reg.last;
    assign m_tdata  = {3'b000, m_pos_reg.col, m_pos_reg.row, m_alive_reg};

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_reg <= col_last_reg)
        else $error("column counter beyond last padded column");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && c_reg == col_last_reg && r_reg == row_last_reg)
        |=> (c_reg == '0 && r_reg == '0))
        else $error("counters did not wrap at end of frame");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && shift) |-> (c_reg != s1_addr_reg))
        else $error("line store read and write hit the same column");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en) |=> s1_valid_reg)
        else $error("stage one item dropped during stall");

endmodule

`default_nettype wire
